// ===== rtl/core/jtok_pkg.sv =====
// Shared types and constants for the JSON tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package jtok_pkg;

    localparam int MAX_TOKENS     = 4096;
    localparam int MAX_TEXT_BYTES = 65536;
    localparam int TOK_W          = 12;
    localparam int CNT_W          = 13;
    localparam int POS_W          = 17;
    localparam int STACK_AW       = $clog2(MAX_TOKENS);

    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(1024);

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    typedef enum logic [1:0] {
        M_NORMAL,
        M_STRING,
        M_PRIM,
        M_HALT
    } t_mode;

    typedef enum logic [2:0] {
        K_OPEN,
        K_CLOSE,
        K_STR,
        K_PRIM,
        K_END
    } t_kind;

    typedef enum logic [1:0] {
        TT_OBJ,
        TT_ARR,
        TT_STR,
        TT_PRIM
    } t_ttype;

    typedef enum logic [2:0] {
        ST_OK,
        ST_NO_TOKEN,
        ST_UNMATCHED,
        ST_UNTERMINATED,
        ST_TOO_LONG
    } t_status;

    // Up to three records caused by one byte: string/primitive done,
    // open/close, end of text.
    typedef struct packed {
        logic              a_vld;
        t_kind             a_kind;
        logic [TOK_W-1:0]  a_tok;
        logic [POS_W-1:0]  a_start;
        logic [POS_W-1:0]  a_end;
        logic              b_vld;
        logic              b_close;
        t_ttype            b_type;
        logic [TOK_W-1:0]  b_tok;
        logic [POS_W-1:0]  b_start;
        logic [POS_W-1:0]  b_end;
        logic              c_vld;
        logic [POS_W-1:0]  c_end;
        logic [CNT_W-1:0]  c_count;
        t_status           c_status;
    } t_entry;

endpackage
`default_nettype wire

// ===== rtl/core/jtok_ram.sv =====
// Generic single-write, single-read RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module jtok_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/jtok_front.sv =====
// Front end: byte classification, parse state, container stacks.
`timescale 1ns / 1ps
`default_nettype none
module jtok_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [jtok_pkg::CNT_W-1:0]   i_cfg_wr_data,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [7:0]                   i_byte,
    input  wire logic                         i_last,
    output logic                              o_ent_valid,
    input  wire logic                         i_ent_ready,
    output jtok_pkg::t_entry                  o_ent
);
    import jtok_pkg::*;

    logic [CNT_W-1:0] r_limit;
    logic [CNT_W-1:0] r_odepth, n_odepth;
    logic [CNT_W-1:0] r_adepth, n_adepth;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_used, n_used;
    t_mode            r_mode, n_mode, mode_mid;
    logic [TOK_W-1:0] r_cur_tok, n_cur_tok;
    logic [POS_W-1:0] r_cur_start, n_cur_start;
    t_status          r_err, n_err;
    logic             r_fv;
    t_entry           r_ent, n_ent;

    logic             accept;
    logic             c_open, c_close, c_obj, c_quote, c_space, c_skip, c_term;
    logic             pos_full, too_long, live, str_end, prim_end, norm;
    logic [CNT_W-1:0] lim, depth_sel;
    logic             room, take, got, no_tok, close_ok, close_bad;
    t_status          fail_code, fail_all;
    logic [POS_W-1:0] pos_inc;
    logic [TOK_W-1:0] cur_tok_mid;
    logic [POS_W-1:0] cur_start_mid;
    logic [CNT_W-1:0] used_mid;
    t_status          err_mid;
    logic             obj_push, arr_push, obj_pop, arr_pop;
    logic [TOK_W-1:0] obj_rd, arr_rd;

    assign accept  = i_valid && o_ready;
    assign o_ready = !r_fv || i_ent_ready;

    assign c_open  = (i_byte == CH_LBRACE) || (i_byte == CH_LBRACK);
    assign c_close = (i_byte == CH_RBRACE) || (i_byte == CH_RBRACK);
    assign c_obj   = (i_byte == CH_LBRACE) || (i_byte == CH_RBRACE);
    assign c_quote = (i_byte == CH_QUOTE);
    assign c_space = (i_byte == CH_SPACE) || (i_byte == CH_TAB) ||
                     (i_byte == CH_CR) || (i_byte == CH_LF);
    assign c_skip  = c_space || (i_byte == CH_COLON) || (i_byte == CH_COMMA);
    assign c_term  = c_space || (i_byte == CH_COMMA) || c_close;

    assign pos_full = (r_pos >= POS_W'(MAX_TEXT_BYTES));
    assign too_long = (r_mode != M_HALT) && pos_full;
    assign live     = (r_mode != M_HALT) && !pos_full;
    assign str_end  = live && (r_mode == M_STRING) && c_quote;
    assign prim_end = live && (r_mode == M_PRIM) && c_term;
    assign norm     = live && ((r_mode == M_NORMAL) || prim_end);

    assign lim       = (r_limit < CNT_W'(MAX_TOKENS)) ? r_limit : CNT_W'(MAX_TOKENS);
    assign room      = (r_used < lim);
    assign take      = norm && !c_close && !c_skip;
    assign got       = take && room;
    assign no_tok    = take && !room;
    assign depth_sel = c_obj ? r_odepth : r_adepth;
    assign close_ok  = norm && c_close && (depth_sel != '0);
    assign close_bad = norm && c_close && (depth_sel == '0);

    assign pos_inc = r_pos + POS_W'(1);

    // next scan mode
    always_comb begin
        if (too_long || no_tok || close_bad) begin
            mode_mid = M_HALT;
        end else if (got && c_quote) begin
            mode_mid = M_STRING;
        end else if (got && !c_open) begin
            mode_mid = M_PRIM;
        end else if (str_end || prim_end) begin
            mode_mid = M_NORMAL;
        end else begin
            mode_mid = r_mode;
        end
        n_mode = i_last ? M_NORMAL : mode_mid;
    end

    always_comb begin
        if (too_long) begin
            fail_code = ST_TOO_LONG;
        end else if (no_tok) begin
            fail_code = ST_NO_TOKEN;
        end else if (close_bad) begin
            fail_code = ST_UNMATCHED;
        end else begin
            fail_code = ST_OK;
        end
        if (fail_code != ST_OK) begin
            fail_all = fail_code;
        end else if (i_last && (mode_mid == M_STRING)) begin
            fail_all = ST_UNTERMINATED;
        end else begin
            fail_all = ST_OK;
        end
        err_mid = (r_err != ST_OK) ? r_err : fail_all;

        used_mid      = r_used + CNT_W'(got);
        cur_tok_mid   = (got && !c_open) ? r_used[TOK_W-1:0] : r_cur_tok;
        if (got && c_quote) begin
            cur_start_mid = pos_inc;
        end else if (got && !c_open) begin
            cur_start_mid = r_pos;
        end else begin
            cur_start_mid = r_cur_start;
        end

        obj_push = got && c_open && c_obj && (r_odepth < CNT_W'(MAX_TOKENS));
        arr_push = got && c_open && !c_obj && (r_adepth < CNT_W'(MAX_TOKENS));
        obj_pop  = close_ok && c_obj;
        arr_pop  = close_ok && !c_obj;

        n_pos       = pos_full ? r_pos : pos_inc;
        n_odepth    = r_odepth + CNT_W'(obj_push) - CNT_W'(obj_pop);
        n_adepth    = r_adepth + CNT_W'(arr_push) - CNT_W'(arr_pop);
        n_used      = used_mid;
        n_cur_tok   = cur_tok_mid;
        n_cur_start = cur_start_mid;
        n_err       = err_mid;
        if (i_last) begin
            n_pos       = '0;
            n_odepth    = '0;
            n_adepth    = '0;
            n_used      = '0;
            n_cur_tok   = '0;
            n_cur_start = '0;
            n_err       = ST_OK;
        end

        n_ent.a_vld   = str_end || prim_end || (i_last && (mode_mid == M_PRIM));
        n_ent.a_kind  = str_end ? K_STR : K_PRIM;
        n_ent.a_tok   = cur_tok_mid;
        n_ent.a_start = cur_start_mid;
        n_ent.a_end   = (str_end || prim_end) ? r_pos : pos_inc;
        n_ent.b_vld   = (got && c_open) || close_ok;
        n_ent.b_close = c_close;
        n_ent.b_type  = c_obj ? TT_OBJ : TT_ARR;
        n_ent.b_tok   = r_used[TOK_W-1:0];
        n_ent.b_start = c_close ? '0 : r_pos;
        n_ent.b_end   = c_close ? pos_inc : '0;
        n_ent.c_vld   = i_last;
        n_ent.c_end   = pos_full ? r_pos : pos_inc;
        n_ent.c_count = used_mid;
        n_ent.c_status = err_mid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LIMIT_RESET;
            r_odepth    <= '0;
            r_adepth    <= '0;
            r_pos       <= '0;
            r_used      <= '0;
            r_mode      <= M_NORMAL;
            r_cur_tok   <= '0;
            r_cur_start <= '0;
            r_err       <= ST_OK;
            r_fv        <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (accept) begin
                r_odepth    <= n_odepth;
                r_adepth    <= n_adepth;
                r_pos       <= n_pos;
                r_used      <= n_used;
                r_mode      <= n_mode;
                r_cur_tok   <= n_cur_tok;
                r_cur_start <= n_cur_start;
                r_err       <= n_err;
                r_fv        <= n_ent.a_vld || n_ent.b_vld || n_ent.c_vld;
            end else if (i_ent_ready) begin
                r_fv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ent <= n_ent;
        end
    end

    jtok_ram #(
        .WIDTH (TOK_W),
        .DEPTH (MAX_TOKENS)
    ) u_obj_stack (
        .i_clk     (i_clk),
        .i_wr_en   (accept && obj_push),
        .i_wr_addr (r_odepth[STACK_AW-1:0]),
        .i_wr_data (r_used[TOK_W-1:0]),
        .i_rd_en   (accept && obj_pop),
        .i_rd_addr (STACK_AW'(r_odepth - CNT_W'(1))),
        .o_rd_data (obj_rd)
    );

    jtok_ram #(
        .WIDTH (TOK_W),
        .DEPTH (MAX_TOKENS)
    ) u_arr_stack (
        .i_clk     (i_clk),
        .i_wr_en   (accept && arr_push),
        .i_wr_addr (r_adepth[STACK_AW-1:0]),
        .i_wr_data (r_used[TOK_W-1:0]),
        .i_rd_en   (accept && arr_pop),
        .i_rd_addr (STACK_AW'(r_adepth - CNT_W'(1))),
        .o_rd_data (arr_rd)
    );

    // popped stack entry comes from the registered RAM read, in step with r_ent
    always_comb begin
        o_ent = r_ent;
        if (r_ent.b_close) begin
            o_ent.b_tok = (r_ent.b_type == TT_OBJ) ? obj_rd : arr_rd;
        end
    end

    assign o_ent_valid = r_fv;

endmodule
`default_nettype wire

// ===== rtl/core/jtok_queue.sv =====
// Short FIFO of decoded entries between front and back.
`timescale 1ns / 1ps
`default_nettype none
module jtok_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    output logic                 o_not_full,
    input  wire jtok_pkg::t_entry i_data,
    input  wire logic            i_pop,
    output logic                 o_not_empty,
    output jtok_pkg::t_entry     o_data
);
    import jtok_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    t_entry            r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [CNT_QW-1:0] r_cnt, n_cnt;
    logic              do_push, do_pop;

    assign o_not_full  = (r_cnt != CNT_QW'(DEPTH));
    assign o_not_empty = (r_cnt != '0);
    assign do_push     = i_push && o_not_full;
    assign do_pop      = i_pop && o_not_empty;
    assign o_data      = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
        end
        n_cnt = r_cnt + CNT_QW'(do_push) - CNT_QW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/jtok_back.sv =====
// Back end: expands entries into token records, output register.
`timescale 1ns / 1ps
`default_nettype none
module jtok_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_ent_valid,
    output logic                              o_ent_pop,
    input  wire jtok_pkg::t_entry             i_ent,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output jtok_pkg::t_kind                   o_kind,
    output logic [jtok_pkg::TOK_W-1:0]        o_tok,
    output jtok_pkg::t_ttype                  o_type,
    output logic [jtok_pkg::POS_W-1:0]        o_start,
    output logic [jtok_pkg::POS_W-1:0]        o_end,
    output logic [jtok_pkg::CNT_W-1:0]        o_count,
    output jtok_pkg::t_status                 o_status,
    output logic                              o_last
);
    import jtok_pkg::*;

    logic [2:0]       r_sent, n_sent;
    logic             r_ov;
    logic [2:0]       pend, sel;
    logic             load, last_pend;
    t_kind            s_kind;
    logic [TOK_W-1:0] s_tok;
    t_ttype           s_type;
    logic [POS_W-1:0] s_start, s_end;
    logic [CNT_W-1:0] s_count;
    t_status          s_status;

    assign pend      = {i_ent.c_vld, i_ent.b_vld, i_ent.a_vld} & ~r_sent;
    assign sel       = pend & (~pend + 3'd1);
    assign last_pend = ((pend & ~sel) == 3'b000);
    assign load      = i_ent_valid && (!r_ov || i_ready);
    assign o_ent_pop = load && last_pend;

    always_comb begin
        s_kind   = K_END;
        s_tok    = '0;
        s_type   = TT_OBJ;
        s_start  = '0;
        s_end    = i_ent.c_end;
        s_count  = i_ent.c_count;
        s_status = i_ent.c_status;
        case (sel)
            3'b001: begin
                s_kind   = i_ent.a_kind;
                s_tok    = i_ent.a_tok;
                s_type   = (i_ent.a_kind == K_STR) ? TT_STR : TT_PRIM;
                s_start  = i_ent.a_start;
                s_end    = i_ent.a_end;
                s_count  = '0;
                s_status = ST_OK;
            end
            3'b010: begin
                s_kind   = i_ent.b_close ? K_CLOSE : K_OPEN;
                s_tok    = i_ent.b_tok;
                s_type   = i_ent.b_type;
                s_start  = i_ent.b_start;
                s_end    = i_ent.b_end;
                s_count  = '0;
                s_status = ST_OK;
            end
            default: begin
            end
        endcase
        if (load) begin
            n_sent = last_pend ? 3'b000 : (r_sent | sel);
        end else begin
            n_sent = r_sent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent <= 3'b000;
            r_ov   <= 1'b0;
        end else begin
            r_sent <= n_sent;
            if (load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_kind   <= s_kind;
            o_tok    <= s_tok;
            o_type   <= s_type;
            o_start  <= s_start;
            o_end    <= s_end;
            o_count  <= s_count;
            o_status <= s_status;
            o_last   <= last_pend;
        end
    end

    assign o_valid = r_ov;

endmodule
`default_nettype wire

// ===== rtl/core/json_tokenizer_unit.sv =====
// Top level of the streaming JSON tokenizer.
//
//  channel  dir  handshake             payload
//  s        in   i_s_tvalid/o_s_tready  tdata: text_byte; tlast: last_byte
//  m        out  o_m_tvalid/i_m_tready  tdata/tuser/tlast: token record
//  cfg      in   i_cfg_wr_en            i_cfg_wr_data: token_limit
//
// One text byte per cycle is accepted while the entry queue has room; one
// record per cycle goes out while the sink is ready; a byte with two or
// three records holds the back end until all are sent. Reset is
// synchronous; stack RAMs need no clearing, so the block is ready right
// after reset. The entry queue lets input run while output stalls.
`timescale 1ns / 1ps
`default_nettype none
module json_tokenizer_unit #(
    parameter int Q_DEPTH = 4
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [jtok_pkg::CNT_W-1:0]  i_cfg_wr_data,
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    input  wire logic [7:0]                  i_s_tdata,   // [7:0] text_byte
    input  wire logic                        i_s_tlast,
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    // [11:0] token_index, [13:12] token_type, [30:14] start_pos,
    // [47:31] end_pos, [60:48] token_count, [63:61] status
    output logic [63:0]                      o_m_tdata,
    output logic [2:0]                       o_m_tuser,   // [2:0] kind
    output logic                             o_m_tlast
);
    import jtok_pkg::*;

    t_entry           f_ent, q_ent;
    logic             f_valid, q_not_full, q_not_empty, b_pop;
    t_kind            m_kind;
    t_ttype           m_type;
    t_status          m_status;
    logic [TOK_W-1:0] m_tok;
    logic [POS_W-1:0] m_start, m_end;
    logic [CNT_W-1:0] m_count;

    jtok_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_s_tvalid),
        .o_ready       (o_s_tready),
        .i_byte        (i_s_tdata),
        .i_last        (i_s_tlast),
        .o_ent_valid   (f_valid),
        .i_ent_ready   (q_not_full),
        .o_ent         (f_ent)
    );

    jtok_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (f_valid),
        .o_not_full  (q_not_full),
        .i_data      (f_ent),
        .i_pop       (b_pop),
        .o_not_empty (q_not_empty),
        .o_data      (q_ent)
    );

    jtok_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ent_valid (q_not_empty),
        .o_ent_pop   (b_pop),
        .i_ent       (q_ent),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_kind      (m_kind),
        .o_tok       (m_tok),
        .o_type      (m_type),
        .o_start     (m_start),
        .o_end       (m_end),
        .o_count     (m_count),
        .o_status    (m_status),
        .o_last      (o_m_tlast)
    );

    assign o_m_tdata = {m_status, m_count, m_end, m_start, m_type, m_tok};
    assign o_m_tuser = m_kind;

endmodule
`default_nettype wire

// ===== tb/json_tokenizer_unit_tb.sv =====
// Self-checking testbench for the streaming JSON tokenizer unit.
`timescale 1ns / 1ps
module json_tokenizer_unit_tb;
    import jtok_pkg::*;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int HOLD_CYCLES  = 200;
    localparam int SETTLE       = 8;

    typedef struct packed {
        t_kind             kind;
        logic [TOK_W-1:0]  idx;
        t_ttype            ttype;
        logic [POS_W-1:0]  spos;
        logic [POS_W-1:0]  epos;
        logic [CNT_W-1:0]  count;
        t_status           status;
        logic              lst;
    } t_tok_rec;

    typedef struct {
        logic [7:0] b;
        bit         lst;
        bit         typed;
        t_tok_rec   want;
    } t_stim_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [CNT_W-1:0]  i_cfg_wr_data;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [7:0]        i_s_tdata;
    logic              i_s_tlast;
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [63:0]       o_m_tdata;
    logic [2:0]        o_m_tuser;
    logic              o_m_tlast;

    json_tokenizer_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tlast     (i_s_tlast),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser),
        .o_m_tlast     (o_m_tlast)
    );

    // tokenizer state mirror
    t_mode             tk_mode;
    logic [TOK_W-1:0]  tk_obj [MAX_TOKENS];
    logic [TOK_W-1:0]  tk_arr [MAX_TOKENS];
    int                tk_obj_dep;
    int                tk_arr_dep;
    int                tk_pos;
    int                tk_used;
    int                tk_cur_tok;
    int                tk_cur_start;
    t_status           tk_err;
    int                tk_limit;

    t_tok_rec          step_recs[$];
    t_tok_rec          pending_tokens[$];
    t_stim_row         dir_rows[$];
    logic [7:0]        text_q[$];
    logic [7:0]        nest_q[$];
    t_tok_rec          blank_rec = '0;

    bit                row_typed;
    t_tok_rec          row_want;
    bit                gaps_on = 1'b1;
    bit                hold_req = 1'b0;
    int                fails = 0;
    int                cycles = 0;

    function automatic t_tok_rec make_rec(t_kind k, int idx, t_ttype tt, int s, int e,
                                          int cnt, t_status st, bit lst);
        t_tok_rec r;
        r.kind   = k;
        r.idx    = TOK_W'(idx);
        r.ttype  = tt;
        r.spos   = POS_W'(s);
        r.epos   = POS_W'(e);
        r.count  = CNT_W'(cnt);
        r.status = st;
        r.lst    = lst;
        return r;
    endfunction

    function automatic void emit(t_kind k, int idx, t_ttype tt, int s, int e, int cnt,
                                 t_status st);
        step_recs.push_back(make_rec(k, idx, tt, s, e, cnt, st, 1'b0));
    endfunction

    function automatic void clear_text();
        tk_mode      = M_NORMAL;
        tk_obj_dep   = 0;
        tk_arr_dep   = 0;
        tk_pos       = 0;
        tk_used      = 0;
        tk_cur_tok   = 0;
        tk_cur_start = 0;
        tk_err       = ST_OK;
    endfunction

    function automatic void halt_with(t_status code);
        if (tk_err == ST_OK) tk_err = code;
        tk_mode = M_HALT;
    endfunction

    function automatic bit alloc_token(output int idx);
        int lim;
        lim = (tk_limit < MAX_TOKENS) ? tk_limit : MAX_TOKENS;
        idx = 0;
        if (tk_used >= lim) begin
            halt_with(ST_NO_TOKEN);
            return 1'b0;
        end
        idx = tk_used;
        tk_used++;
        return 1'b1;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    function automatic bit is_special(logic [7:0] c);
        return c == CH_LBRACE || c == CH_LBRACK || c == CH_RBRACE || c == CH_RBRACK ||
               c == CH_QUOTE || c == CH_COLON || c == CH_COMMA || is_blank(c);
    endfunction

    function automatic void scan_plain(logic [7:0] c, int p);
        int idx;
        if (c == CH_LBRACE) begin
            if (!alloc_token(idx)) return;
            tk_obj[tk_obj_dep] = TOK_W'(idx);
            tk_obj_dep++;
            emit(K_OPEN, idx, TT_OBJ, p, 0, 0, ST_OK);
        end else if (c == CH_LBRACK) begin
            if (!alloc_token(idx)) return;
            tk_arr[tk_arr_dep] = TOK_W'(idx);
            tk_arr_dep++;
            emit(K_OPEN, idx, TT_ARR, p, 0, 0, ST_OK);
        end else if (c == CH_RBRACE) begin
            if (tk_obj_dep == 0) begin
                halt_with(ST_UNMATCHED);
                return;
            end
            tk_obj_dep--;
            emit(K_CLOSE, tk_obj[tk_obj_dep], TT_OBJ, 0, p + 1, 0, ST_OK);
        end else if (c == CH_RBRACK) begin
            if (tk_arr_dep == 0) begin
                halt_with(ST_UNMATCHED);
                return;
            end
            tk_arr_dep--;
            emit(K_CLOSE, tk_arr[tk_arr_dep], TT_ARR, 0, p + 1, 0, ST_OK);
        end else if (c == CH_QUOTE) begin
            if (!alloc_token(idx)) return;
            tk_cur_tok   = idx;
            tk_cur_start = p + 1;
            tk_mode      = M_STRING;
        end else if (!(is_blank(c) || c == CH_COLON || c == CH_COMMA)) begin
            if (!alloc_token(idx)) return;
            tk_cur_tok   = idx;
            tk_cur_start = p;
            tk_mode      = M_PRIM;
        end
    endfunction

    // Token records caused by one text beat, in output order.
    function automatic void tokenize_byte(logic [7:0] c, bit lst);
        int p;
        p = tk_pos;
        step_recs.delete();
        if (tk_mode != M_HALT) begin
            if (p >= MAX_TEXT_BYTES) begin
                halt_with(ST_TOO_LONG);
            end else if (tk_mode == M_STRING) begin
                if (c == CH_QUOTE) begin
                    emit(K_STR, tk_cur_tok, TT_STR, tk_cur_start, p, 0, ST_OK);
                    tk_mode = M_NORMAL;
                end
            end else if (tk_mode == M_PRIM) begin
                if (c == CH_COMMA || c == CH_RBRACK || c == CH_RBRACE || is_blank(c)) begin
                    emit(K_PRIM, tk_cur_tok, TT_PRIM, tk_cur_start, p, 0, ST_OK);
                    tk_mode = M_NORMAL;
                    scan_plain(c, p);
                end
            end else begin
                scan_plain(c, p);
            end
        end
        if (tk_pos < MAX_TEXT_BYTES) tk_pos++;
        if (lst) begin
            if (tk_mode == M_STRING) begin
                halt_with(ST_UNTERMINATED);
            end else if (tk_mode == M_PRIM) begin
                emit(K_PRIM, tk_cur_tok, TT_PRIM, tk_cur_start, p + 1, 0, ST_OK);
            end
            emit(K_END, 0, TT_OBJ, 0, tk_pos, tk_used, tk_err);
            clear_text();
        end
        if (step_recs.size() != 0) step_recs[step_recs.size() - 1].lst = 1'b1;
    endfunction

    function automatic void show(string tag, t_tok_rec r);
        $display("  %s kind=%0d idx=%0d type=%0d start=%0d end=%0d count=%0d status=%0d last=%0b",
                 tag, r.kind, r.idx, r.ttype, r.spos, r.epos, r.count, r.status, r.lst);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // sink side: random stalls, plus one long hold-off
    initial begin : sink
        int held;
        held = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && held < HOLD_CYCLES) begin
                i_m_tready <= 1'b0;
                held++;
            end else if (gaps_on && $urandom_range(0, 99) < 30) begin
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : scoreboard
        t_tok_rec got;
        t_tok_rec want;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                tokenize_byte(i_s_tdata, i_s_tlast);
                if (row_typed) pending_tokens.push_back(row_want);
                else foreach (step_recs[i]) pending_tokens.push_back(step_recs[i]);
            end
            if (o_m_tvalid && i_m_tready) begin
                got.kind   = t_kind'(o_m_tuser);
                got.idx    = o_m_tdata[11:0];
                got.ttype  = t_ttype'(o_m_tdata[13:12]);
                got.spos   = o_m_tdata[30:14];
                got.epos   = o_m_tdata[47:31];
                got.count  = o_m_tdata[60:48];
                got.status = t_status'(o_m_tdata[63:61]);
                got.lst    = o_m_tlast;
                if (pending_tokens.size() == 0) begin
                    if (fails < 10) begin
                        $display("unexpected token record at cycle %0d", cycles);
                        show("actual  ", got);
                    end
                    fails++;
                end else begin
                    want = pending_tokens.pop_front();
                    if (got.kind !== want.kind || got.idx !== want.idx ||
                        got.ttype !== want.ttype || got.spos !== want.spos ||
                        got.epos !== want.epos || got.count !== want.count ||
                        got.status !== want.status || got.lst !== want.lst) begin
                        if (fails < 10) begin
                            $display("token record mismatch at cycle %0d", cycles);
                            show("expected", want);
                            show("actual  ", got);
                        end
                        fails++;
                    end
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit lst, input bit typed,
                             input t_tok_rec want);
        @(negedge i_clk);
        while (gaps_on && $urandom_range(0, 99) < 30) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= lst;
        row_typed = typed;
        row_want  = want;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic send_text();
        foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1, 1'b0, blank_rec);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_tokens.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_limit(input int v);
        drain();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= CNT_W'(v);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        tk_limit = v;
    endtask

    function automatic void add_row(logic [7:0] b, bit lst);
        t_stim_row r;
        r.b     = b;
        r.lst   = lst;
        r.typed = 1'b0;
        r.want  = '0;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_typed(logic [7:0] b, bit lst, t_kind k, int idx, t_ttype tt,
                                      int s, int e, int cnt, t_status st);
        t_stim_row r;
        r.b     = b;
        r.lst   = lst;
        r.typed = 1'b1;
        r.want  = make_rec(k, idx, tt, s, e, cnt, st, 1'b1);
        dir_rows.push_back(r);
    endfunction

    function automatic logic [7:0] pick_struct();
        case ($urandom_range(0, 10))
            0: return CH_LBRACE;
            1: return CH_RBRACE;
            2: return CH_LBRACK;
            3: return CH_RBRACK;
            4: return CH_QUOTE;
            5: return CH_COLON;
            6: return CH_COMMA;
            7: return CH_SPACE;
            8: return CH_TAB;
            9: return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] pick_sep();
        case ($urandom_range(0, 5))
            0: return CH_COMMA;
            1: return CH_COLON;
            2: return CH_SPACE;
            3: return CH_TAB;
            4: return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] pick_prim_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (is_special(c));
        return c;
    endfunction

    function automatic void close_top();
        text_q.push_back(nest_q.pop_back() == CH_LBRACE ? CH_RBRACE : CH_RBRACK);
    endfunction

    // Mostly nested text with random content, not always closed; some noise and truncation.
    function automatic void build_text();
        int steps;
        int r;
        int k;
        logic [7:0] c;
        text_q.delete();
        nest_q.delete();
        if ($urandom_range(0, 99) < 15) begin
            k = $urandom_range(1, 12);
            repeat (k) text_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                                             : pick_struct());
            return;
        end
        steps = $urandom_range(1, 8);
        repeat (steps) begin
            r = $urandom_range(0, 9);
            if (r < 3 && nest_q.size() < 4) begin
                c = $urandom_range(0, 1) ? CH_LBRACE : CH_LBRACK;
                text_q.push_back(c);
                nest_q.push_back(c);
            end else if (r < 5) begin
                text_q.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 4)) begin
                    c = 8'($urandom_range(0, 255));
                    text_q.push_back(c == CH_QUOTE ? CH_LBRACE : c);
                end
                text_q.push_back(CH_QUOTE);
            end else if (r < 7) begin
                repeat ($urandom_range(1, 4)) text_q.push_back(pick_prim_char());
                if (nest_q.size() != 0 && $urandom_range(0, 2) == 0) close_top();
                else if ($urandom_range(0, 3) != 0) text_q.push_back(pick_sep());
            end else if (r < 8 && nest_q.size() != 0) begin
                close_top();
            end else begin
                text_q.push_back(pick_sep());
            end
        end
        while (nest_q.size() != 0 && $urandom_range(0, 3) != 0) close_top();
        if ($urandom_range(0, 9) == 0 && text_q.size() > 1)
            text_q = text_q[0:$urandom_range(0, text_q.size() - 2)];
    endfunction

    initial begin : stimulus
        int limits [6];
        int sent;

        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tlast     = 1'b0;
        row_typed     = 1'b0;
        row_want      = '0;
        tk_limit      = LIMIT_RESET;
        clear_text();

        // nested text with all token kinds, then error and end-of-text cases
        add_typed(CH_LBRACE, 0, K_OPEN, 0, TT_OBJ, 0, 0, 0, ST_OK);
        add_row(CH_QUOTE, 0);
        add_row("a", 0);
        add_row(CH_QUOTE, 0);
        add_row(CH_COLON, 0);
        add_row(CH_LBRACK, 0);
        add_row("1", 0);
        add_row(CH_COMMA, 0);
        add_row(8'hFF, 0);
        add_row(CH_RBRACK, 0);
        add_row(8'h00, 0);
        add_row(CH_RBRACE, 1);
        add_row(CH_RBRACK, 0);
        add_typed("x", 1, K_END, 0, TT_OBJ, 0, 2, 0, ST_UNMATCHED);
        add_typed(CH_QUOTE, 1, K_END, 0, TT_OBJ, 0, 1, 1, ST_UNTERMINATED);
        add_row(CH_TAB, 0);
        add_row(CH_CR, 0);
        add_row(CH_LF, 0);
        add_row(CH_SPACE, 0);
        add_row("z", 1);
        add_typed(CH_RBRACE, 1, K_END, 0, TT_OBJ, 0, 1, 0, ST_UNMATCHED);
        add_row(CH_LBRACK, 1);

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_byte(dir_rows[i].b, dir_rows[i].lst, dir_rows[i].typed, dir_rows[i].want);

        limits = '{1, 2, 5, MAX_TOKENS, 0, int'(LIMIT_RESET)};
        limits[4] = $urandom_range(3, 12);
        for (int ph = 0; ph < 6; ph++) begin
            write_limit(limits[ph]);
            gaps_on = (ph != 4);
            if (ph == 3) hold_req = 1'b1;
            sent = 0;
            while (sent < 30) begin
                build_text();
                send_text();
                sent += text_q.size();
                if (ph == 1) drain();
            end
        end

        drain();
        repeat (20) @(negedge i_clk);
        if (fails == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== json_tokenizer_unit.f =====
rtl/core/jtok_pkg.sv
rtl/core/jtok_ram.sv
rtl/core/jtok_front.sv
rtl/core/jtok_queue.sv
rtl/core/jtok_back.sv
rtl/core/json_tokenizer_unit.sv
tb/json_tokenizer_unit_tb.sv
